[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the sender RTL. Synthesis gets empty
// bodies.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_RST(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(name, clk, rst, prop, msg)
`define ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

[rtl/swsf_pkg.sv]
// ----------------------------------------------------------------------------
// Stop-and-wait sender package
// Event, flag and phase codes, and the types shared by the sender modules.
// ----------------------------------------------------------------------------
package swsf_pkg;

  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_OPEN   = 3'd1;
  localparam logic [2:0] ACT_SEND   = 3'd2;
  localparam logic [2:0] ACT_FINISH = 3'd3;
  localparam logic [2:0] ACT_CLOSE  = 3'd4;
  localparam logic [2:0] ACT_RX     = 3'd5;

  localparam logic [2:0] FL_DATA   = 3'd0;
  localparam logic [2:0] FL_SYN    = 3'd1;
  localparam logic [2:0] FL_ACK    = 3'd2;
  localparam logic [2:0] FL_ACKSYN = 3'd3;
  localparam logic [2:0] FL_FIN    = 3'd4;
  localparam logic [2:0] FL_FINACK = 3'd5;
  localparam logic [2:0] FL_OVER   = 3'd7;

  localparam logic [2:0] PH_CLOSED   = 3'd0;
  localparam logic [2:0] PH_SYNWAIT  = 3'd1;
  localparam logic [2:0] PH_READY    = 3'd2;
  localparam logic [2:0] PH_DATAWAIT = 3'd3;
  localparam logic [2:0] PH_OVERWAIT = 3'd4;
  localparam logic [2:0] PH_FINWAIT  = 3'd5;
  localparam logic [2:0] PH_FINAL    = 3'd6;
  localparam logic [2:0] PH_ERROR    = 3'd7;

  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_CONNECTED = 3'd1;
  localparam logic [2:0] EV_CONFIRMED = 3'd2;
  localparam logic [2:0] EV_ENDED     = 3'd3;
  localparam logic [2:0] EV_CLOSED    = 3'd4;
  localparam logic [2:0] EV_HS_ERROR  = 3'd5;

  localparam logic [10:0] MAX_PAYLOAD = 11'd1024;
  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  typedef struct packed {
    logic [2:0]  phase;
    logic [7:0]  next_seq;
    logic [31:0] wait_timer;
    logic [10:0] pending_len;
  } link_state_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  rx_flag;
    logic [7:0]  rx_seq;
    logic        rx_check_ok;
    logic [10:0] data_len;
  } event_item_t;

  typedef struct packed {
    logic [2:0]  event_code;
    logic [2:0]  link_phase;
    logic        tx_retry;
    logic [10:0] tx_len;
    logic [7:0]  tx_seq;
    logic [2:0]  tx_flag;
    logic        tx_valid;
  } result_item_t;

endpackage

[rtl/swsf_step.sv]
// ----------------------------------------------------------------------------
// Stop-and-wait sender step logic
// Computes the next link state and the result item for one event.
// ----------------------------------------------------------------------------
module swsf_step import swsf_pkg::*; (
  input  link_state_t  st,
  input  event_item_t  item,
  input  logic [31:0]  timeout_ticks,
  output link_state_t  st_next,
  output result_item_t res,
  output logic         res_en
);

  logic [31:0] limit;
  logic [32:0] cnt;

  assign limit = (timeout_ticks == 32'd0) ? 32'd1 : timeout_ticks;
  assign cnt   = {1'b0, st.wait_timer} + 33'd1;

  always_comb begin
    st_next = st;
    res     = '0;
    res_en  = 1'b0;
    case (item.action)
      ACT_TICK: begin
        if (st.phase != PH_CLOSED && st.phase != PH_READY && st.phase != PH_ERROR) begin
          if (cnt < {1'b0, limit}) begin
            st_next.wait_timer = cnt[31:0];
          end else begin
            st_next.wait_timer = '0;
            res_en       = 1'b1;
            res.tx_valid = 1'b1;
            res.tx_retry = 1'b1;
            case (st.phase)
              PH_SYNWAIT:  res.tx_flag = FL_SYN;
              PH_DATAWAIT: begin
                res.tx_flag = FL_DATA;
                res.tx_seq  = st.next_seq;
                res.tx_len  = st.pending_len;
              end
              PH_OVERWAIT: res.tx_flag = FL_OVER;
              PH_FINWAIT:  res.tx_flag = FL_FIN;
              default:     res.tx_flag = FL_FINACK;
            endcase
          end
        end
      end
      ACT_OPEN: begin
        if (st.phase == PH_CLOSED || st.phase == PH_ERROR) begin
          st_next.next_seq   = '0;
          st_next.phase      = PH_SYNWAIT;
          st_next.wait_timer = '0;
          res_en       = 1'b1;
          res.tx_valid = 1'b1;
          res.tx_flag  = FL_SYN;
        end
      end
      ACT_SEND: begin
        if (st.phase == PH_READY) begin
          st_next.pending_len = (item.data_len > MAX_PAYLOAD) ? MAX_PAYLOAD : item.data_len;
          st_next.phase       = PH_DATAWAIT;
          st_next.wait_timer  = '0;
          res_en       = 1'b1;
          res.tx_valid = 1'b1;
          res.tx_flag  = FL_DATA;
          res.tx_seq   = st.next_seq;
          res.tx_len   = st_next.pending_len;
        end
      end
      ACT_FINISH: begin
        if (st.phase == PH_READY) begin
          st_next.phase      = PH_OVERWAIT;
          st_next.wait_timer = '0;
          res_en       = 1'b1;
          res.tx_valid = 1'b1;
          res.tx_flag  = FL_OVER;
        end
      end
      ACT_CLOSE: begin
        if (st.phase == PH_READY) begin
          st_next.phase      = PH_FINWAIT;
          st_next.wait_timer = '0;
          res_en       = 1'b1;
          res.tx_valid = 1'b1;
          res.tx_flag  = FL_FIN;
        end
      end
      ACT_RX: begin
        case (st.phase)
          PH_SYNWAIT: begin
            st_next.wait_timer = '0;
            res_en = 1'b1;
            if (item.rx_flag == FL_ACK && item.rx_check_ok) begin
              st_next.phase  = PH_READY;
              res.tx_valid   = 1'b1;
              res.tx_flag    = FL_ACKSYN;
              res.event_code = EV_CONNECTED;
            end else begin
              st_next.phase  = PH_ERROR;
              res.event_code = EV_HS_ERROR;
            end
          end
          PH_DATAWAIT: begin
            if (item.rx_flag == FL_ACK && item.rx_seq == st.next_seq) begin
              st_next.next_seq   = st.next_seq + 8'd1;
              st_next.phase      = PH_READY;
              st_next.wait_timer = '0;
              res_en         = 1'b1;
              res.event_code = EV_CONFIRMED;
            end
          end
          PH_OVERWAIT: begin
            if (item.rx_flag == FL_OVER) begin
              st_next.next_seq   = '0;
              st_next.phase      = PH_READY;
              st_next.wait_timer = '0;
              res_en         = 1'b1;
              res.event_code = EV_ENDED;
            end
          end
          PH_FINWAIT: begin
            st_next.wait_timer = '0;
            res_en = 1'b1;
            if (item.rx_flag == FL_ACK && item.rx_check_ok) begin
              st_next.phase = PH_FINAL;
              res.tx_valid  = 1'b1;
              res.tx_flag   = FL_FINACK;
            end else begin
              st_next.phase  = PH_ERROR;
              res.event_code = EV_HS_ERROR;
            end
          end
          PH_FINAL: begin
            st_next.phase      = PH_CLOSED;
            st_next.wait_timer = '0;
            res_en         = 1'b1;
            res.event_code = EV_CLOSED;
          end
          default: begin
            res_en = 1'b0;
          end
        endcase
      end
      default: begin
        res_en = 1'b0;
      end
    endcase
    res.link_phase = st_next.phase;
  end

endmodule

[rtl/stop_and_wait_sender_fsm.sv]
// ----------------------------------------------------------------------------
// Stop-and-wait sender
// Sender control of a reliable datagram link with timeout retransmission.
// ----------------------------------------------------------------------------
// An event is taken into the input register; its result is held in the output register.
// Throughput: one event per cycle; the output register frees the input side.
// An event is held only while its result waits behind a stalled output.
// Reset clears the link state and sets the timeout to 1000 ticks.
module stop_and_wait_sender_fsm import swsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] action
  input  logic [2:0]  s_axis_tuser,
  // [2:0] rx_flag, [10:3] rx_seq, [11] rx_check_ok, [22:12] data_len, [23] zero
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] tx_valid, [3:1] tx_flag, [11:4] tx_seq, [22:12] tx_len, [23] tx_retry,
  // [26:24] link_phase, [29:27] event_code, [31:30] zero
  output logic [31:0] m_axis_tdata
);

`include "assert_macros.svh"

  logic [31:0]  timeout_ticks;
  link_state_t  st;
  link_state_t  st_next;
  event_item_t  item;
  logic         item_valid;
  result_item_t res;
  logic         res_en;
  result_item_t out_item;
  logic         out_valid;
  logic         advance;

  swsf_step u_step (
    .st            (st),
    .item          (item),
    .timeout_ticks (timeout_ticks),
    .st_next       (st_next),
    .res           (res),
    .res_en        (res_en)
  );

  assign advance       = item_valid && (!res_en || !out_valid || m_axis_tready);
  assign s_axis_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_ticks <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item.action      <= s_axis_tuser;
      item.rx_flag     <= s_axis_tdata[2:0];
      item.rx_seq      <= s_axis_tdata[10:3];
      item.rx_check_ok <= s_axis_tdata[11];
      item.data_len    <= s_axis_tdata[22:12];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_en) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_en) begin
      out_item <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_item};

  `ASSERT_ALWAYS(a_out_clear_after_rst, clk, $past(rst) |-> !m_axis_tvalid,
    "output valid after reset")
  `ASSERT_RST(a_idle_timer_zero, clk, rst,
    (st.phase == PH_CLOSED || st.phase == PH_READY || st.phase == PH_ERROR) |->
    (st.wait_timer == 32'd0), "timer running in a non-waiting phase")
  `ASSERT_RST(a_empty_takes_item, clk, rst, !item_valid |-> s_axis_tready,
    "empty input stage refuses an item")
  `ASSERT_RST(a_event_only_result, clk, rst,
    (m_axis_tvalid && !out_item.tx_valid) |-> (out_item.event_code != EV_NONE),
    "result carries neither packet nor event")

endmodule
